### design/lmt_pkg.sv
// ----------------------------------------------------------------------------
// lmt_pkg: shared types and constants of the Legendre moment tally
// Default parameter values, register indexes, the divider request, the
// 64-bit magnitude helper and the 48-bit saturation helper.
// ----------------------------------------------------------------------------
package lmt_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_ORDER = 15;
    localparam int DEF_FRAC_BITS = 16;

    // Fixed datapath widths
    localparam int ACC_W   = 48;
    localparam int DVD_W   = 64;
    localparam int DSR_W   = 32;
    localparam int CNT_W   = 16;
    localparam int PADDR_W = 4;

    // Configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_LEFT  = 2'd0;
    localparam logic [1:0] REG_RIGHT = 2'd1;
    localparam logic [1:0] REG_ORDER = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_WAIT,
        ST_TERM,
        ST_TERM_WAIT,
        ST_MUL,
        ST_POLY,
        ST_POLY_WAIT,
        ST_COUNT,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_EMIT
    } t_state;

    // Divider control
    typedef struct packed {
        logic start;
        logic neg;
    } t_div_req;

    // Magnitude of a signed 64-bit value
    function automatic logic [DVD_W-1:0] mag64(input logic signed [DVD_W-1:0] v);
        return v[DVD_W-1] ? DVD_W'(-v) : DVD_W'(v);
    endfunction

    // Clamp a wide signed sum to the 48-bit range
    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [DVD_W+1:0] v);
        logic signed [DVD_W+1:0] hi;
        logic signed [DVD_W+1:0] lo;
        hi = (DVD_W+2)'(48'sh7FFF_FFFF_FFFF);
        lo = (DVD_W+2)'(48'sh8000_0000_0000);
        if (v > hi) begin
            return ACC_W'(hi);
        end else if (v < lo) begin
            return ACC_W'(lo);
        end
        return ACC_W'(v);
    endfunction

endpackage

### design/lmt_div.sv
// ----------------------------------------------------------------------------
// lmt_div: shared restoring divider
// Unsigned 64 / 32 bit division, one quotient bit per cycle; the sign of the
// quotient is applied on the way out. Truncates toward zero.
// ----------------------------------------------------------------------------
module lmt_div
    import lmt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_req                i_req,
    input  logic [DVD_W-1:0]        i_dividend,
    input  logic [DSR_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [DVD_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DSR_W:0]    r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DSR_W-1:0]  r_dsr;
    logic              r_neg;

    logic [DSR_W:0]    trial;
    logic              fits;

    // One trial subtraction per cycle
    assign trial = {r_rem[DSR_W-1:0], r_quo[DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dsr});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dsr}) : trial;
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

### design/legendre_moment_tally.sv
// ----------------------------------------------------------------------------
// legendre_moment_tally: Legendre functional-expansion tally
// Accumulates per-order Legendre moments of interaction samples weighted by
// the inverse cross-section, and emits running totals of batch means.
// ----------------------------------------------------------------------------
// Usage:
//  - Samples arrive on i_valid/o_ready with position, cross-section and
//    end_batch; one transaction per sample. o_ready is high only when idle.
//  - Per sample: the position is mapped to -1..1 (one division unless it
//    lies outside the domain or the domain is empty or reversed), then
//    each order up to the limited order_in_use needs a term division and,
//    except the last, a recurrence division. Every division runs on one
//    shared 64-step divider.
//  - A sample with end_batch set then emits one result per order on
//    o_valid/i_ready, each after its own mean division and a pass through
//    the output register.
//    A stalled receiver holds the block in place; nothing is lost.
//  - Reset clears registers to their defaults, sums, totals and counters.
//  - Configuration via APB (pready always high), only while idle.
// ----------------------------------------------------------------------------
module legendre_moment_tally
    import lmt_pkg::*;
#(
    parameter int MAX_ORDER = DEF_MAX_ORDER,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // APB configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // Sample channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [31:0]      i_position,
    input  logic [31:0]             i_cross_section,
    input  logic                    i_end_batch,
    // Result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [3:0]              o_order_index,
    output logic signed [ACC_W-1:0] o_total_coeff,
    output logic [CNT_W-1:0]        o_batches_done,
    output logic                    o_last
);

    localparam int NW    = (MAX_ORDER < 2) ? 1 : $clog2(MAX_ORDER + 1);
    localparam int DEPTH = MAX_ORDER + 1;
    localparam logic signed [DVD_W-1:0] ONE = DVD_W'(1) <<< FRAC_BITS;

    // Registers
    t_state                   r_state, n_state;
    logic signed [31:0]       r_left, r_right;
    logic [3:0]               r_order;
    logic [DSR_W-1:0]         r_xs, n_xs;
    logic                     r_eb, n_eb;
    logic [NW-1:0]            r_ord, n_ord;
    logic [NW-1:0]            r_n, n_n;
    logic signed [31:0]       r_x, n_x;
    logic signed [31:0]       r_p, n_p;
    logic signed [31:0]       r_pp, n_pp;
    logic signed [DVD_W-1:0]  r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_batch [DEPTH];
    logic signed [ACC_W-1:0]  n_batch [DEPTH];
    logic signed [ACC_W-1:0]  r_total [DEPTH];
    logic signed [ACC_W-1:0]  n_total [DEPTH];
    logic [CNT_W-1:0]         r_scount, n_scount;
    logic [CNT_W-1:0]         r_bcount, n_bcount;
    logic                     r_out_valid, n_out_valid;
    logic [3:0]               r_out_idx, n_out_idx;
    logic signed [ACC_W-1:0]  r_out_tot, n_out_tot;
    logic                     r_out_last, n_out_last;

    // Divider hookup
    t_div_req                 div_req;
    logic [DVD_W-1:0]         div_dvd;
    logic [DSR_W-1:0]         div_dsr;
    logic                     div_done;
    logic signed [DVD_W-1:0]  div_quo;

    // Combinational helpers
    logic                     cfg_wr;
    logic [NW-1:0]            ord_lim;
    logic signed [32:0]       den;
    logic signed [32:0]       pos_off;
    logic signed [DVD_W-1:0]  pval;
    logic signed [DVD_W-1:0]  num;
    logic signed [DVD_W-1:0]  bsum;
    logic [6:0]               coef;

    lmt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= 32'(ONE);
            r_order <= 4'd3;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LEFT:  r_left  <= pwdata;
                REG_RIGHT: r_right <= pwdata;
                REG_ORDER: r_order <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LEFT:  prdata = r_left;
            REG_RIGHT: prdata = r_right;
            REG_ORDER: prdata = {28'd0, r_order};
            default:   prdata = '0;
        endcase
    end

    // Operand preparation
    assign ord_lim = (int'(r_order) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(r_order);
    assign den     = 33'(r_right) - 33'(r_left);
    assign pos_off = 33'(i_position) - 33'(r_left);
    assign pval    = DVD_W'(r_p) <<< FRAC_BITS;
    assign coef    = {r_n, 1'b1} + 7'd0;
    assign num     = r_prod * $signed({1'b0, coef})
                   - (DVD_W'(r_pp * $signed({1'b0, r_n})) <<< FRAC_BITS);
    assign bsum    = DVD_W'(r_batch[r_n]);

    // State register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scount    <= '0;
            r_bcount    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_batch[i] <= '0;
                r_total[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_scount    <= n_scount;
            r_bcount    <= n_bcount;
            r_out_valid <= n_out_valid;
            r_batch     <= n_batch;
            r_total     <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xs       <= n_xs;
        r_eb       <= n_eb;
        r_ord      <= n_ord;
        r_n        <= n_n;
        r_x        <= n_x;
        r_p        <= n_p;
        r_pp       <= n_pp;
        r_prod     <= n_prod;
        r_out_idx  <= n_out_idx;
        r_out_tot  <= n_out_tot;
        r_out_last <= n_out_last;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_xs        = r_xs;
        n_eb        = r_eb;
        n_ord       = r_ord;
        n_n         = r_n;
        n_x         = r_x;
        n_p         = r_p;
        n_pp        = r_pp;
        n_prod      = r_prod;
        n_batch     = r_batch;
        n_total     = r_total;
        n_scount    = r_scount;
        n_bcount    = r_bcount;
        n_out_valid = r_out_valid;
        n_out_idx   = r_out_idx;
        n_out_tot   = r_out_tot;
        n_out_last  = r_out_last;
        div_req     = '0;
        div_dvd     = '0;
        div_dsr     = '0;
        o_ready     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_xs  = (i_cross_section == '0) ? DSR_W'(1) : i_cross_section;
                    n_eb  = i_end_batch;
                    n_ord = ord_lim;
                    n_n   = '0;
                    n_p   = 32'(ONE);
                    n_pp  = '0;
                    n_state = ST_TERM;
                    // Map position onto -1..1, clamping outside the domain
                    if (den <= 0) begin
                        n_x = '0;
                    end else if (pos_off < 0) begin
                        n_x = -32'(ONE);
                    end else if (pos_off >= den) begin
                        n_x = 32'(ONE);
                    end else begin
                        div_req.start = 1'b1;
                        div_dvd = DVD_W'(pos_off[31:0]) << (FRAC_BITS + 1);
                        div_dsr = den[31:0];
                        n_state = ST_MAP_WAIT;
                    end
                end
            end
            ST_MAP_WAIT: begin
                if (div_done) begin
                    n_x     = 32'(div_quo - ONE);
                    n_state = ST_TERM;
                end
            end
            // P_n / cross-section
            ST_TERM: begin
                div_req.start = 1'b1;
                div_req.neg   = r_p[31];
                div_dvd       = mag64(pval);
                div_dsr       = r_xs;
                n_state       = ST_TERM_WAIT;
            end
            ST_TERM_WAIT: begin
                if (div_done) begin
                    n_batch[r_n] = sat48((DVD_W+2)'(r_batch[r_n]) + (DVD_W+2)'(div_quo));
                    n_state = (r_n == r_ord) ? ST_COUNT : ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = DVD_W'(r_x * r_p);
                n_state = ST_POLY;
            end
            // Recurrence numerator over (n+1) * ONE
            ST_POLY: begin
                div_req.start = 1'b1;
                div_req.neg   = num[DVD_W-1];
                div_dvd       = mag64(num);
                div_dsr       = DSR_W'(DSR_W'(r_n) + DSR_W'(1)) << FRAC_BITS;
                n_state       = ST_POLY_WAIT;
            end
            ST_POLY_WAIT: begin
                if (div_done) begin
                    n_pp    = r_p;
                    n_p     = div_quo[31:0];
                    n_n     = r_n + 1'b1;
                    n_state = ST_TERM;
                end
            end
            ST_COUNT: begin
                if (r_scount != '1) begin
                    n_scount = r_scount + 1'b1;
                end
                if (r_eb) begin
                    if (r_bcount != '1) begin
                        n_bcount = r_bcount + 1'b1;
                    end
                    n_n     = '0;
                    n_state = ST_MEAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            // Batch mean of order n
            ST_MEAN: begin
                div_req.start = 1'b1;
                div_req.neg   = bsum[DVD_W-1];
                div_dvd       = mag64(bsum);
                div_dsr       = DSR_W'(r_scount);
                n_state       = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (div_done) begin
                    n_total[r_n] = sat48((DVD_W+2)'(r_total[r_n]) + (DVD_W+2)'(div_quo));
                    n_out_valid  = 1'b1;
                    n_out_idx    = 4'(r_n);
                    n_out_tot    = n_total[r_n];
                    n_out_last   = (r_n == r_ord);
                    n_state      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_out_valid && i_ready) begin
                    n_out_valid = 1'b0;
                    if (r_n == r_ord) begin
                        for (int i = 0; i < DEPTH; i++) begin
                            n_batch[i] = '0;
                        end
                        n_scount = '0;
                        n_state  = ST_IDLE;
                    end else begin
                        n_n     = r_n + 1'b1;
                        n_state = ST_MEAN;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Result outputs
    assign o_valid        = r_out_valid;
    assign o_order_index  = r_out_idx;
    assign o_total_coeff  = r_out_tot;
    assign o_batches_done = r_bcount;
    assign o_last         = r_out_last;

endmodule

### verif/lmt_checker.sv
// ----------------------------------------------------------------------------
// lmt_checker: result predictor and scoreboard for the Legendre moment tally
// Follows the register writes on the APB port, predicts the per-order totals
// for every accepted sample and compares each result transaction in order.
// ----------------------------------------------------------------------------
module lmt_checker
    import lmt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [31:0]             pwdata,
    input  logic                    pready,
    input  logic                    i_valid,
    input  logic                    o_ready,
    input  logic signed [31:0]      i_position,
    input  logic [31:0]             i_cross_section,
    input  logic                    i_end_batch,
    input  logic                    o_valid,
    input  logic                    i_ready,
    input  logic [3:0]              o_order_index,
    input  logic signed [ACC_W-1:0] o_total_coeff,
    input  logic [CNT_W-1:0]        o_batches_done,
    input  logic                    o_last,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam longint ONE     = longint'(1) << DEF_FRAC_BITS;
    localparam longint ACC_MAX = (longint'(1) << 47) - 1;
    localparam longint ACC_MIN = -(longint'(1) << 47);

    typedef struct packed {
        logic [3:0]              order;
        logic signed [ACC_W-1:0] coeff;
        logic [CNT_W-1:0]        batches;
        logic                    last;
    } t_moment;

    t_moment expected_moments[$];

    // Mirror of the block's configuration and tally state
    longint dom_left;
    longint dom_right;
    int     top_order;
    longint order_sums[DEF_MAX_ORDER+1];
    longint order_totals[DEF_MAX_ORDER+1];
    int     samples_in_batch;
    int     batches_closed;
    int     fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = expected_moments.size();

    function automatic longint clamp_acc(input longint v);
        if (v > ACC_MAX) return ACC_MAX;
        if (v < ACC_MIN) return ACC_MIN;
        return v;
    endfunction

    // Position onto -1..1, clamped; zero for an empty or reversed domain
    function automatic longint unit_position(input longint pos);
        longint span;
        longint x;
        span = dom_right - dom_left;
        if (span <= 0) return 0;
        x = ((pos - dom_left) * (2 * ONE)) / span - ONE;
        if (x > ONE) x = ONE;
        if (x < -ONE) x = -ONE;
        return x;
    endfunction

    task automatic tally_sample(input longint pos, input longint xs, input logic closes);
        longint  x;
        longint  p_prev;
        longint  p;
        longint  p_next;
        longint  mean;
        int      ord;
        t_moment m;
        ord    = (top_order > DEF_MAX_ORDER) ? DEF_MAX_ORDER : top_order;
        x      = unit_position(pos);
        p_prev = 0;
        p      = ONE;
        if (xs == 0) xs = 1;
        // Legendre recurrence, one term per order
        for (int n = 0; n <= ord; n++) begin
            order_sums[n] = clamp_acc(order_sums[n] + (p * ONE) / xs);
            p_next = (longint'(2 * n + 1) * x * p - longint'(n) * p_prev * ONE)
                     / (longint'(n + 1) * ONE);
            p_prev = p;
            p      = p_next;
        end
        if (samples_in_batch < 16'hFFFF) samples_in_batch++;
        if (!closes) return;
        // Batch close: fold the means into the totals
        if (batches_closed < 16'hFFFF) batches_closed++;
        for (int n = 0; n <= ord; n++) begin
            mean            = order_sums[n] / longint'(samples_in_batch);
            order_totals[n] = clamp_acc(order_totals[n] + mean);
            m.order   = 4'(n);
            m.coeff   = ACC_W'(order_totals[n]);
            m.batches = CNT_W'(batches_closed);
            m.last    = (n == ord);
            expected_moments = {expected_moments, m};
        end
        for (int n = 0; n <= DEF_MAX_ORDER; n++) order_sums[n] = 0;
        samples_in_batch = 0;
    endtask

    always @(posedge i_clk) begin
        t_moment want;
        if (!i_rst_n) begin
            dom_left         = 0;
            dom_right        = ONE;
            top_order        = 3;
            samples_in_batch = 0;
            batches_closed   = 0;
            for (int n = 0; n <= DEF_MAX_ORDER; n++) begin
                order_sums[n]   = 0;
                order_totals[n] = 0;
            end
        end else begin
            // Register write
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_LEFT:  dom_left  = longint'($signed(pwdata));
                    REG_RIGHT: dom_right = longint'($signed(pwdata));
                    REG_ORDER: top_order = int'(pwdata[3:0]);
                    default: ;
                endcase
            end
            // Result transaction against the oldest expectation
            if (o_valid && i_ready) begin
                if (expected_moments.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: unexpected result order=%0d coeff=%0d batches=%0d",
                                 o_order_index, o_total_coeff, o_batches_done);
                end else begin
                    want = expected_moments.pop_front();
                    if (o_order_index !== want.order || o_total_coeff !== want.coeff ||
                        o_batches_done !== want.batches || o_last !== want.last) begin
                        fails++;
                        if (fails <= 10)
                            $display({"ERROR: result mismatch exp order=%0d coeff=%0d ",
                                      "batches=%0d last=%0d got order=%0d coeff=%0d ",
                                      "batches=%0d last=%0d"},
                                     want.order, want.coeff, want.batches, want.last,
                                     o_order_index, o_total_coeff, o_batches_done, o_last);
                    end
                end
            end
            // Sample transaction
            if (i_valid && o_ready)
                tally_sample(longint'(i_position), longint'(i_cross_section), i_end_batch);
        end
    end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the Legendre moment tally
// Directed samples cover domain edges, odd cross-sections and order changes,
// then random batches run under three idling patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import lmt_pkg::*;

    localparam int  ONE_Q        = 1 << DEF_FRAC_BITS;
    localparam int  CYCLE_LIMIT  = 6000000;
    localparam int  SETTLE_TICKS = 3000;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [PADDR_W-1:0]      paddr   = '0;
    logic [31:0]             pwdata  = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic signed [31:0]      i_position      = '0;
    logic [31:0]             i_cross_section = '0;
    logic                    i_end_batch     = 1'b0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [3:0]              o_order_index;
    logic signed [ACC_W-1:0] o_total_coeff;
    logic [CNT_W-1:0]        o_batches_done;
    logic                    o_last;

    int fail_count;
    int pending;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    legendre_moment_tally dut (.*);

    lmt_checker scoreboard (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .i_valid, .o_ready, .i_position, .i_cross_section, .i_end_batch,
        .o_valid, .i_ready, .o_order_index, .o_total_coeff, .o_batches_done, .o_last,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // One sample transaction; valid stays up on return for a back-to-back follow-on
    task automatic send_sample(input logic [31:0] pos, input logic [31:0] xs,
                               input logic closes);
        if ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_position      <= pos;
        i_cross_section <= xs;
        i_end_batch     <= closes;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Drop valid and let every outstanding result and trailing work finish
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random setup: mostly sane domains and low orders, now and then extremes
    task automatic random_setup;
        int lo;
        int span;
        lo   = $signed($urandom_range(0, 2 * ONE_Q * 8)) - 8 * ONE_Q;
        span = $urandom_range(1, 16 * ONE_Q);
        if ($urandom_range(9) == 0) begin
            reg_write(REG_LEFT, $urandom());
            reg_write(REG_RIGHT, $urandom());
        end else begin
            reg_write(REG_LEFT, lo);
            reg_write(REG_RIGHT, lo + span);
        end
        reg_write(REG_ORDER, ($urandom_range(7) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 4));
    endtask

    task automatic random_phase(input int sample_total);
        logic [31:0] pos;
        logic [31:0] xs;
        for (int k = 0; k < sample_total; k++) begin
            pos = ($urandom_range(3) == 0) ? $urandom()
                  : 32'($signed($urandom_range(0, 20 * ONE_Q)) - 10 * ONE_Q);
            case ($urandom_range(3))
                0:       xs = $urandom();
                1:       xs = $urandom_range(1, 255);
                default: xs = $urandom_range(ONE_Q / 4, 4 * ONE_Q);
            endcase
            if (k % 35 == 17) begin
                drain();
                random_setup();
            end
            send_sample(pos, xs, (k == sample_total - 1) || ($urandom_range(5) == 0));
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default domain, field extremes, odd cross-sections
        send_sample(32'd0, ONE_Q, 1'b0);
        send_sample(ONE_Q, ONE_Q, 1'b0);
        send_sample(32'h8000_0000, 32'd1, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'd0, 1'b0);
        send_sample(32'h0000_8000, 32'hFFFF_FFFF, 1'b1);
        drain();

        // Widest domain at the top order
        reg_write(REG_LEFT, 32'h8000_0000);
        reg_write(REG_RIGHT, 32'h7FFF_FFFF);
        reg_write(REG_ORDER, 32'd15);
        send_sample(32'h8000_0000, 32'd3, 1'b0);
        send_sample(32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
        send_sample(32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
        drain();

        // Reversed and empty domains at order zero
        reg_write(REG_LEFT, ONE_Q);
        reg_write(REG_RIGHT, 32'd0);
        reg_write(REG_ORDER, 32'd0);
        send_sample(32'h5555_5555, 32'd7, 1'b1);
        drain();
        reg_write(REG_RIGHT, ONE_Q);
        send_sample(ONE_Q, 32'd0, 1'b1);
        drain();

        // Order raised and lowered within one batch
        reg_write(REG_LEFT, 32'hFFFF_0000);
        reg_write(REG_ORDER, 32'd6);
        send_sample(32'hFFFF_8000, ONE_Q, 1'b0);
        drain();
        reg_write(REG_ORDER, 32'd2);
        send_sample(32'h0000_4000, 32'd2, 1'b0);
        send_sample(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        drain();

        // Random: three idling patterns
        send_gap_pct   = 27;
        recv_stall_pct = 66;
        random_setup();
        random_phase(135);
        send_gap_pct   = 66;
        recv_stall_pct = 27;
        random_setup();
        random_phase(135);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        random_setup();
        random_phase(135);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
